FILE: rtl/bdec_pkg.sv
// package for the button debounce event classifier
// holds shared constants, the event code enum and the config and result structs
// no dependencies
package bdec_pkg;

  localparam int unsigned HoldCountBits = 16;
  localparam int unsigned HoldLimitBits = 16;
  localparam int unsigned HoldCmpBits   =
    (HoldCountBits > HoldLimitBits) ? HoldCountBits : HoldLimitBits;

  localparam int unsigned CfgIndexBits = 2;
  localparam int unsigned CfgDataBits  = 16;

  localparam logic [7:0]               IntegratorMaxReset = 8'd5;
  localparam logic [7:0]               EvalPeriodReset    = 8'd5;
  localparam logic [HoldLimitBits-1:0] HoldLimitReset     = HoldLimitBits'(60);

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_INTEGRATOR_MAX = 2'd0,
    CFG_EVAL_PERIOD    = 2'd1,
    CFG_HOLD_LIMIT     = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_HELD     = 2'd2,
    EV_RELEASED = 2'd3
  } event_e;

  typedef struct packed {
    logic [7:0]               integrator_max;
    logic [7:0]               eval_period;
    logic [HoldLimitBits-1:0] hold_limit;
  } cfg_t;

  typedef struct packed {
    logic   debounced;
    logic   long_press;
    event_e event_res;
  } result_t;

endpackage

FILE: rtl/bdec_cfg.sv
// configuration register file for the button debounce event classifier
// holds integrator_max, eval_period and hold_limit; depends on bdec_pkg
module bdec_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bdec_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [bdec_pkg::CfgDataBits-1:0]     cfg_data_i,
  output bdec_pkg::cfg_t                       cfg_o
);

  bdec_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_index_i)
        bdec_pkg::CFG_INTEGRATOR_MAX: cfg_d.integrator_max = cfg_data_i[7:0];
        bdec_pkg::CFG_EVAL_PERIOD:    cfg_d.eval_period    = cfg_data_i[7:0];
        bdec_pkg::CFG_HOLD_LIMIT:
          cfg_d.hold_limit = cfg_data_i[bdec_pkg::HoldLimitBits-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.integrator_max <= bdec_pkg::IntegratorMaxReset;
      cfg_q.eval_period    <= bdec_pkg::EvalPeriodReset;
      cfg_q.hold_limit     <= bdec_pkg::HoldLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/bdec_core.sv
// debounce state and event logic: integrator, tick divider, pressed flag, hold count
// computes one result per accepted sample; depends on bdec_pkg
module bdec_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                raw_level_i,
  input  bdec_pkg::cfg_t      cfg_i,
  output bdec_pkg::result_t   result_o
);

  logic [7:0]                         integ_q, integ_d;
  logic [7:0]                         div_q, div_d;
  logic                               flag_q, flag_d;
  logic [bdec_pkg::HoldCountBits-1:0] hold_q, hold_d;

  logic [7:0] top;
  logic [7:0] period;
  logic [7:0] integ_n;
  logic [7:0] div_inc;
  logic       eval;

  assign top    = (cfg_i.integrator_max == 8'd0) ? 8'd1 : cfg_i.integrator_max;
  assign period = (cfg_i.eval_period == 8'd0) ? 8'd1 : cfg_i.eval_period;

  always_comb begin
    if (raw_level_i) begin
      integ_n = (integ_q != 8'd0) ? integ_q - 8'd1 : integ_q;
    end else begin
      integ_n = (integ_q < top) ? integ_q + 8'd1 : top;
    end
  end

  assign div_inc = div_q + 8'd1;
  assign eval    = (div_inc >= period);

  always_comb begin
    integ_d              = integ_q;
    div_d                = div_q;
    flag_d               = flag_q;
    hold_d               = hold_q;
    result_o.event_res   = bdec_pkg::EV_NONE;
    result_o.long_press  = 1'b0;
    if (step_i) begin
      integ_d = integ_n;
      div_d   = eval ? 8'd0 : div_inc;
      if (eval) begin
        if (integ_n >= top) begin
          result_o.event_res = flag_q ? bdec_pkg::EV_HELD : bdec_pkg::EV_PRESSED;
          if (hold_q != '1) begin
            hold_d = hold_q + 1'b1;
          end
          flag_d = 1'b1;
          result_o.long_press = flag_q &&
            (bdec_pkg::HoldCmpBits'(hold_d) > bdec_pkg::HoldCmpBits'(cfg_i.hold_limit));
        end else if (integ_n == 8'd0) begin
          result_o.event_res = flag_q ? bdec_pkg::EV_RELEASED : bdec_pkg::EV_NONE;
          hold_d = '0;
          flag_d = 1'b0;
        end
      end
    end
    result_o.debounced = flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      div_q   <= '0;
      flag_q  <= 1'b0;
      hold_q  <= '0;
    end else begin
      integ_q <= integ_d;
      div_q   <= div_d;
      flag_q  <= flag_d;
      hold_q  <= hold_d;
    end
  end

endmodule

FILE: rtl/button_debounce_event_classifier.sv
// Button debounce event classifier. Each input transaction carries one raw
// active-low button sample; each one yields exactly one result transaction with
// the event code (none, pressed, held, released), a long-press flag and the
// debounced state. The state update and classification happen in the cycle the
// sample is accepted, and the result lands in an output register, so it is
// offered in the next cycle; a new sample is taken every cycle while the
// result register is empty or being drained. Configuration writes are taken at
// any time and should only be issued while the block is idle.
// depends on bdec_pkg, bdec_cfg and bdec_core
module button_debounce_event_classifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [0] raw_level
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [1:0] event_res, [2] long_press,
                                                           // [3] debounced
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bdec_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [bdec_pkg::CfgDataBits-1:0]  cfg_data_i
);

  bdec_pkg::cfg_t    cfg;
  bdec_pkg::result_t result;
  bdec_pkg::result_t res_q;
  logic              out_valid_q, out_valid_d;
  logic              step;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  bdec_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bdec_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .raw_level_i (s_axis_tdata[0]),
    .cfg_i       (cfg),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.debounced, res_q.long_press, res_q.event_res};

endmodule
